@@ rtl/pcdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdp_pkg
// Shared types, register codes and reset values for the point-to-depth-pixel projector.
// ----------------------------------------------------------------------------
package pcdp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;

	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [19:0] RST_FOCAL_X      = 20'd130089;
	localparam logic [19:0] RST_FOCAL_Y      = 20'd130089;
	localparam logic [19:0] RST_CENTER_X     = 20'd82662;
	localparam logic [19:0] RST_CENTER_Y     = 20'd64079;

	localparam logic [9:0]  MM_PER_M = 10'd1000;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic               point_valid;
	} point_t;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
		logic [15:0] depth_mm;
	} pixel_t;

endpackage

@@ rtl/point_cloud_depth_projection_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cloud_depth_projection_top
// Pinhole projection of one 3-D point per cycle into a depth-pixel write.
// ----------------------------------------------------------------------------
// Takes one point request per clock while the output is not stalled and,
// once the pipeline is full, returns at most one pixel write per clock.
// QB = clog2(MAX_SIDE)+1. From accept to the output register a point
// passes a stage of five multipliers, a stage of numerator sums, then one
// restoring-division step per quotient bit, column and row side by side
// sharing the divisor z*512. Dropped points (NaN, z <= 0, negative or
// out-of-image pixel) still travel the pipeline as bubbles and simply never
// show up at the output. The whole pipeline advances together whenever the
// output register is empty or being taken, so in_ready falls only while a
// finished pixel waits on out_ready. Write registers only while idle.
module point_cloud_depth_projection_top #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pcdp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcdp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pcdp_pkg::point_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pcdp_pkg::pixel_t                out_data
);

	localparam int QB = $clog2(MAX_SIDE) + 1;   // quotient bits, 2^QB > MAX_SIDE
	localparam int W  = 48 + QB;                // remainder / compare width
	localparam int LW = (QB > 13) ? QB : 13;    // limit compare width

	// configuration registers
	logic [12:0] img_w_q, img_h_q;
	logic [19:0] fx_q, fy_q, cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= pcdp_pkg::RST_IMAGE_WIDTH;
			img_h_q <= pcdp_pkg::RST_IMAGE_HEIGHT;
			fx_q    <= pcdp_pkg::RST_FOCAL_X;
			fy_q    <= pcdp_pkg::RST_FOCAL_Y;
			cx_q    <= pcdp_pkg::RST_CENTER_X;
			cy_q    <= pcdp_pkg::RST_CENTER_Y;
		end else if (cfg_we) begin
			case (cfg_index)
				pcdp_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data[12:0];
				pcdp_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data[12:0];
				pcdp_pkg::REG_FOCAL_X:      fx_q    <= cfg_data;
				pcdp_pkg::REG_FOCAL_Y:      fy_q    <= cfg_data;
				pcdp_pkg::REG_CENTER_X:     cx_q    <= cfg_data;
				pcdp_pkg::REG_CENTER_Y:     cy_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: hold everything while a finished pixel waits
	logic out_valid_q;
	pcdp_pkg::pixel_t out_data_q;
	logic adv;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: products ----------------
	logic               v_s1, ok_s1;
	logic signed [44:0] pfx_s1, pcx_s1, pfy_s1, pcy_s1;
	logic signed [23:0] z_s1;
	logic signed [34:0] zk_s1;
	logic               ok_in;

	// drop NaN and z <= 0 (covers the all-zero point)
	assign ok_in = in_data.point_valid && !in_data.pos_z[23] && (in_data.pos_z != 24'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1  <= ok_in;
			pfx_s1 <= $signed({1'b0, fx_q}) * in_data.pos_x;
			pcx_s1 <= $signed({1'b0, cx_q}) * in_data.pos_z;
			pfy_s1 <= $signed({1'b0, fy_q}) * in_data.pos_y;
			pcy_s1 <= $signed({1'b0, cy_q}) * in_data.pos_z;
			z_s1   <= in_data.pos_z;
			zk_s1  <= $signed({1'b0, pcdp_pkg::MM_PER_M}) * in_data.pos_z;
		end
	end

	// ---------------- stage 2 and divider stages ----------------
	// index 0 is stage 2; index k+1 is after quotient bit QB-1-k
	logic          v_sd    [0:QB];
	logic          ok_sd   [0:QB];
	logic          negc_sd [0:QB];
	logic          negr_sd [0:QB];
	logic          ovfc_sd [0:QB];
	logic          ovfr_sd [0:QB];
	logic [31:0]   d_sd    [0:QB];
	logic [W-1:0]  remc_sd [0:QB];
	logic [W-1:0]  remr_sd [0:QB];
	logic [QB-1:0] qc_sd   [0:QB];
	logic [QB-1:0] qr_sd   [0:QB];
	logic [15:0]   dep_sd  [0:QB];

	logic signed [45:0] num_c, num_r;
	logic [45:0]        mag_c, mag_r;
	logic [31:0]        den;     // 2*z*256
	logic [47:0]        nc, nr;  // 2*|num| + z*256
	logic [W-1:0]       dtop;
	logic [34:0]        zk_rnd;
	logic [18:0]        dep_full;

	assign num_c    = {pfx_s1[44], pfx_s1} + {pcx_s1[44], pcx_s1};
	assign num_r    = {pfy_s1[44], pfy_s1} + {pcy_s1[44], pcy_s1};
	assign mag_c    = num_c[45] ? 46'(-num_c) : 46'(num_c);
	assign mag_r    = num_r[45] ? 46'(-num_r) : 46'(num_r);
	assign den      = {z_s1[22:0], 9'd0};
	assign nc       = {1'b0, mag_c, 1'b0} + {17'd0, z_s1[22:0], 8'd0};
	assign nr       = {1'b0, mag_r, 1'b0} + {17'd0, z_s1[22:0], 8'd0};
	assign dtop     = W'(den) << QB;
	assign zk_rnd   = 35'(zk_s1) + 35'd32768;
	assign dep_full = 19'(zk_rnd[34:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sd[0] <= 1'b0;
		else if (adv) v_sd[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_sd[0]   <= ok_s1;
			negc_sd[0] <= num_c[45];
			negr_sd[0] <= num_r[45];
			ovfc_sd[0] <= W'(nc) >= dtop;
			ovfr_sd[0] <= W'(nr) >= dtop;
			d_sd[0]    <= den;
			remc_sd[0] <= W'(nc);
			remr_sd[0] <= W'(nr);
			qc_sd[0]   <= '0;
			qr_sd[0]   <= '0;
			dep_sd[0]  <= (dep_full > 19'd65535) ? 16'hFFFF : dep_full[15:0];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [W-1:0] trial;
		logic         gec, ger;

		assign trial = W'(d_sd[k]) << SH;
		assign gec   = remc_sd[k] >= trial;
		assign ger   = remr_sd[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sd[k+1] <= 1'b0;
			else if (adv) v_sd[k+1] <= v_sd[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ok_sd[k+1]   <= ok_sd[k];
				negc_sd[k+1] <= negc_sd[k];
				negr_sd[k+1] <= negr_sd[k];
				ovfc_sd[k+1] <= ovfc_sd[k];
				ovfr_sd[k+1] <= ovfr_sd[k];
				d_sd[k+1]    <= d_sd[k];
				dep_sd[k+1]  <= dep_sd[k];
				remc_sd[k+1] <= gec ? remc_sd[k] - trial : remc_sd[k];
				remr_sd[k+1] <= ger ? remr_sd[k] - trial : remr_sd[k];
				qc_sd[k+1]   <= qc_sd[k] | (QB'(gec) << SH);
				qr_sd[k+1]   <= qr_sd[k] | (QB'(ger) << SH);
			end
		end
	end

	// ---------------- final checks and output register ----------------
	logic [LW-1:0] lim_w, lim_h;
	logic          col_ok, row_ok, pass;

	assign lim_w  = (LW'(img_w_q) > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : LW'(img_w_q);
	assign lim_h  = (LW'(img_h_q) > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : LW'(img_h_q);
	// negative pixel survives only when it rounds to zero
	assign col_ok = !ovfc_sd[QB] && !(negc_sd[QB] && (qc_sd[QB] != '0))
		&& (LW'(qc_sd[QB]) < lim_w);
	assign row_ok = !ovfr_sd[QB] && !(negr_sd[QB] && (qr_sd[QB] != '0))
		&& (LW'(qr_sd[QB]) < lim_h);
	assign pass   = v_sd[QB] && ok_sd[QB] && col_ok && row_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= pass;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.pixel_col <= 12'(qc_sd[QB]);
			out_data_q.pixel_row <= 12'(qr_sd[QB]);
			out_data_q.depth_mm  <= dep_sd[QB];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- assertions ----------------
	a_col_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (LW'(out_data_q.pixel_col) < lim_w))
		else $error("pixel column outside image");

	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (LW'(out_data_q.pixel_row) < lim_h))
		else $error("pixel row outside image");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_sd[QB]) && $stable(qc_sd[QB]) && $stable(qr_sd[QB]))
		else $error("pipeline moved during stall");

endmodule

@@ test/point_cloud_depth_projection_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cloud_depth_projection_top_tb
// Self-checking bench for the point-to-depth-pixel projector.
// ----------------------------------------------------------------------------
// Streams directed and random point requests through the projector under
// several camera setups. A local pinhole model predicts each pixel write,
// and every write coming out is compared field by field against it.
// ----------------------------------------------------------------------------
module point_cloud_depth_projection_top_tb;

	localparam logic [pcdp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Scoreboard: predicts pixel writes from accepted requests and checks them.
	class pixel_scoreboard;
		logic [12:0]      img_w, img_h;
		logic [19:0]      fx, fy, cx, cy;
		pcdp_pkg::pixel_t pending[$];
		int               errors;
		int               matched;

		function new();
			errors  = 0;
			matched = 0;
			set_defaults();
		endfunction

		function void set_defaults();
			img_w = pcdp_pkg::RST_IMAGE_WIDTH;
			img_h = pcdp_pkg::RST_IMAGE_HEIGHT;
			fx    = pcdp_pkg::RST_FOCAL_X;
			fy    = pcdp_pkg::RST_FOCAL_Y;
			cx    = pcdp_pkg::RST_CENTER_X;
			cy    = pcdp_pkg::RST_CENTER_Y;
		endfunction

		function void write_reg(logic [pcdp_pkg::CFG_IDX_W-1:0] idx,
				logic [pcdp_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				pcdp_pkg::REG_IMAGE_WIDTH:  img_w = val[12:0];
				pcdp_pkg::REG_IMAGE_HEIGHT: img_h = val[12:0];
				pcdp_pkg::REG_FOCAL_X:      fx = val;
				pcdp_pkg::REG_FOCAL_Y:      fy = val;
				pcdp_pkg::REG_CENTER_X:     cx = val;
				pcdp_pkg::REG_CENTER_Y:     cy = val;
				default: ;
			endcase
		endfunction

		// Round num/den half away from zero; negative flags a result below zero.
		function automatic longint unsigned round_half(longint num, longint den,
				output bit negative);
			longint unsigned mag, q;
			mag      = (num < 0) ? longint'(-num) : num;
			q        = (2 * mag + den) / (2 * den);
			negative = (num < 0) && (q != 0);
			return q;
		endfunction

		function void note_point(pcdp_pkg::point_t p);
			longint x, y, z, den;
			longint unsigned col, row, depth, wlim, hlim;
			bit nc, nr;
			pcdp_pkg::pixel_t px;
			x = p.pos_x;
			y = p.pos_y;
			z = p.pos_z;
			if (!p.point_valid || z <= 0)
				return;
			den = z * 256;
			col = round_half(longint'(fx) * x + longint'(cx) * z, den, nc);
			row = round_half(longint'(fy) * y + longint'(cy) * z, den, nr);
			if (nc || nr)
				return;
			wlim = (img_w > 4096) ? 4096 : img_w;
			hlim = (img_h > 4096) ? 4096 : img_h;
			if (col >= wlim || row >= hlim)
				return;
			depth = (z * 2000 + 65536) / 131072;
			if (depth > 65535)
				depth = 65535;
			px.pixel_col = col[11:0];
			px.pixel_row = row[11:0];
			px.depth_mm  = depth[15:0];
			pending.push_back(px);
		endfunction

		task check_pixel(pcdp_pkg::pixel_t got);
			pcdp_pkg::pixel_t exp_px;
			if (pending.size() == 0) begin
				report_error($sformatf("unexpected pixel write %p", got));
				return;
			end
			exp_px = pending.pop_front();
			if (got.pixel_col !== exp_px.pixel_col)
				report_error($sformatf("col %0d, want %0d", got.pixel_col, exp_px.pixel_col));
			if (got.pixel_row !== exp_px.pixel_row)
				report_error($sformatf("row %0d, want %0d", got.pixel_row, exp_px.pixel_row));
			if (got.depth_mm !== exp_px.depth_mm)
				report_error($sformatf("depth %0d, want %0d", got.depth_mm, exp_px.depth_mm));
			matched++;
		endtask

		task report_error(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pcdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcdp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pcdp_pkg::point_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pcdp_pkg::pixel_t out_data;

	pixel_scoreboard board;
	int requests_sent;
	bit drain_stalls;

	always #10 clk = ~clk;

	point_cloud_depth_projection_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	// Sample at the rising edge; note requests and check pixel writes.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			board.note_point(in_data);
			requests_sent++;
		end
		if (arst_n && out_valid && out_ready)
			board.check_pixel(out_data);
	end

	// Receiver side: random stall length per pixel, sometimes none at all.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = (drain_stalls || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(logic [pcdp_pkg::CFG_IDX_W-1:0] idx,
			logic [pcdp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, val);
	endtask

	// Hold valid and payload until the request is taken; drop valid only on a gap.
	task automatic send_point(pcdp_pkg::point_t p, int gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_gap(pcdp_pkg::point_t p);
		send_point(p, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0);
	endtask

	// Wait until every predicted pixel is out, then let the pipeline drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic pcdp_pkg::point_t make_point(int x, int y, int z, bit v);
		pcdp_pkg::point_t p;
		p.pos_x       = 24'(x);
		p.pos_y       = 24'(y);
		p.pos_z       = 24'(z);
		p.point_valid = v;
		return p;
	endfunction

	// Random point aimed mostly into the image: pick pixel then back-project.
	function automatic pcdp_pkg::point_t random_point();
		int z, sel;
		longint w, h, u, v, x, y;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return pcdp_pkg::point_t'(73'({$urandom, $urandom, $urandom}));
		z = (sel == 1) ? $urandom_range(1, 8388607) : $urandom_range(1, 400000);
		if (sel == 2)
			z = -$urandom_range(0, 8388608);
		w = (board.img_w == 0) ? 1 : board.img_w;
		h = (board.img_h == 0) ? 1 : board.img_h;
		u = $urandom_range(0, 32'((w + 8) * 256)) - 1024;
		v = $urandom_range(0, 32'((h + 8) * 256)) - 1024;
		// x = (u - cx) * z / fx, all in Q.8 pixels
		x = (board.fx == 0) ? $signed($urandom_range(0, 65535)) - 32768 :
			((u - longint'(board.cx)) * z) / longint'(board.fx);
		y = (board.fy == 0) ? $signed($urandom_range(0, 65535)) - 32768 :
			((v - longint'(board.cy)) * z) / longint'(board.fy);
		if (x > 8388607) x = 8388607;
		if (x < -8388608) x = -8388608;
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		return make_point(int'(x), int'(y), z, $urandom_range(0, 15) != 0);
	endfunction

	task automatic random_phase(int count);
		repeat (count) send_random_gap(random_point());
		settle();
	endtask

	initial begin
		board = new();
		requests_sent = 0;
		drain_stalls = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: special cases with reset intrinsics.
		send_point(make_point(0, 0, 65536, 0), 0);              // NaN point
		send_point(make_point(0, 0, 0, 1), 0);                  // all-zero point
		send_point(make_point(100, 100, 0, 1), 0);              // z zero
		send_point(make_point(0, 0, -65536, 1), 0);             // z negative
		send_point(make_point(0, 0, -8388608, 1), 0);           // most negative z
		send_point(make_point(0, 0, 65536, 1), 0);              // center pixel
		send_point(make_point(0, 0, 8388607, 1), 0);            // deep, saturated
		send_point(make_point(0, 0, 1, 1), 0);                  // tiny z
		send_point(make_point(-8388608, 0, 65536, 1), 0);       // far left, dropped
		send_point(make_point(8388607, 8388607, 65536, 1), 0);  // far off, dropped
		send_point(make_point(-8388608, -8388608, 8388607, 1), 0);
		send_point(make_point(-41664, -32320, 65536, 1), 0);    // near column zero
		send_point(make_point(-41700, 0, 65536, 1), 0);         // just below zero
		send_point(make_point(0, 0, 65, 1), 0);                 // depth rounds to 1
		send_point(make_point(0, 0, 98, 1), 0);                 // depth just under a half
		settle();

		// Zero-sized image drops everything; oversize clamps at the maximum side.
		write_reg(pcdp_pkg::REG_IMAGE_WIDTH, 20'd0);
		write_reg(pcdp_pkg::REG_IMAGE_HEIGHT, 20'd0);
		send_point(make_point(0, 0, 65536, 1), 0);
		random_phase(60);
		write_reg(pcdp_pkg::REG_IMAGE_WIDTH, 20'hFFFFF);
		write_reg(pcdp_pkg::REG_IMAGE_HEIGHT, 20'd8191);
		write_reg(pcdp_pkg::REG_FOCAL_X, 20'hFFFFF);
		write_reg(pcdp_pkg::REG_FOCAL_Y, 20'hFFFFF);
		write_reg(pcdp_pkg::REG_CENTER_X, 20'hFFFFF);
		write_reg(pcdp_pkg::REG_CENTER_Y, 20'hFFFFF);
		write_reg(REG_UNUSED, 20'h12345);
		send_point(make_point(-8388608, -8388608, 65536, 1), 0);
		random_phase(250);

		// Zero focal length and principal point at the origin.
		write_reg(pcdp_pkg::REG_FOCAL_X, 20'd0);
		write_reg(pcdp_pkg::REG_FOCAL_Y, 20'd0);
		write_reg(pcdp_pkg::REG_CENTER_X, 20'd0);
		write_reg(pcdp_pkg::REG_CENTER_Y, 20'd0);
		write_reg(pcdp_pkg::REG_IMAGE_WIDTH, 20'd1);
		write_reg(pcdp_pkg::REG_IMAGE_HEIGHT, 20'd1);
		random_phase(150);

		// Random intrinsics and image sizes across a few setups.
		repeat (3) begin
			write_reg(pcdp_pkg::REG_IMAGE_WIDTH, 20'($urandom_range(1, 4096)));
			write_reg(pcdp_pkg::REG_IMAGE_HEIGHT, 20'($urandom_range(1, 4096)));
			write_reg(pcdp_pkg::REG_FOCAL_X, 20'($urandom_range(0, 20'hFFFFF)));
			write_reg(pcdp_pkg::REG_FOCAL_Y, 20'($urandom_range(0, 20'hFFFFF)));
			write_reg(pcdp_pkg::REG_CENTER_X, 20'($urandom_range(0, 20'hFFFFF)));
			write_reg(pcdp_pkg::REG_CENTER_Y, 20'($urandom_range(0, 20'hFFFFF)));
			random_phase(200);
		end

		// Back to camera-like defaults, last stretch without receiver stalls.
		write_reg(pcdp_pkg::REG_IMAGE_WIDTH, 20'(pcdp_pkg::RST_IMAGE_WIDTH));
		write_reg(pcdp_pkg::REG_IMAGE_HEIGHT, 20'(pcdp_pkg::RST_IMAGE_HEIGHT));
		write_reg(pcdp_pkg::REG_FOCAL_X, pcdp_pkg::RST_FOCAL_X);
		write_reg(pcdp_pkg::REG_FOCAL_Y, pcdp_pkg::RST_FOCAL_Y);
		write_reg(pcdp_pkg::REG_CENTER_X, pcdp_pkg::RST_CENTER_X);
		write_reg(pcdp_pkg::REG_CENTER_Y, pcdp_pkg::RST_CENTER_Y);
		random_phase(300);
		drain_stalls = 1;
		repeat (300) send_point(random_point(), 0);
		settle();

		$display("Sent %0d point requests, checked %0d pixel writes over several setups.",
			requests_sent, board.matched);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("Timeout waiting for the projector");
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pcdp_pkg.sv
rtl/point_cloud_depth_projection_top.sv
test/point_cloud_depth_projection_top_tb.sv
